FILE: rtl/swm_pkg.sv
// Package: shared constants and controller/datapath command and status types
`default_nettype none
package swm_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int ADDR_W     = $clog2(WINDOW_MAX);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int DATA_W     = 32;
  localparam int WS_W       = 7;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;

  typedef struct packed {
    logic accept;     // take the request, apply first flag and clamps
    logic pop;        // drop deque head
    logic rd_tail;    // address deque tail
    logic drop_tail;  // drop deque tail
    logic push;       // write sample to deque and delay line
    logic emit;       // load output register
  } swm_cmd_t;

  typedef struct packed {
    logic pop_hit;
    logic count_zero;
    logic tail_smaller;
    logic seen_full;
    logic out_free;
  } swm_stat_t;

endpackage
`default_nettype wire

FILE: rtl/swm_intf.sv
// Interfaces: sample request channel and result channel
`default_nettype none
interface swm_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [swm_pkg::DATA_W-1:0]  sample;
  logic                               first_of_sequence;
  logic                               last_of_sequence;

  modport source (output valid, output sample, output first_of_sequence,
                  output last_of_sequence, input ready);
  modport sink   (input valid, input sample, input first_of_sequence,
                  input last_of_sequence, output ready);
endinterface

interface swm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [swm_pkg::DATA_W-1:0]  window_max;
  logic                               last_result;

  modport source (output valid, output window_max, output last_result, input ready);
  modport sink   (input valid, input window_max, input last_result, output ready);
endinterface
`default_nettype wire

FILE: rtl/swm_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/swm_datapath.sv
// Datapath: deque and delay line RAMs, pointers, counters and output register
`default_nettype none
module swm_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [swm_pkg::WS_W-1:0]          window_size,
  input  wire logic signed [swm_pkg::DATA_W-1:0] in_sample,
  input  wire logic                              in_first,
  input  wire logic                              in_last,
  input  wire swm_pkg::swm_cmd_t                 cmd,
  output swm_pkg::swm_stat_t                     stat,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [swm_pkg::DATA_W-1:0]      out_window_max,
  output logic                                   out_last
);
  import swm_pkg::*;

  logic [DATA_W-1:0] sample_r, sample_nxt;
  logic              last_r, last_nxt;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] widx_r, widx_nxt;
  logic [CNT_W-1:0]  seen_r, seen_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  logic [CNT_W-1:0]  win_w;
  logic [ADDR_W-1:0] head_base, widx_base, head_adj;
  logic [CNT_W-1:0]  seen_base, count_adj, widx_inc;
  logic              deque_full;

  logic [ADDR_W-1:0] cand_raddr, cand_waddr;
  logic [DATA_W-1:0] cand_q, rec_q;

  // window size clamped to 1..WINDOW_MAX
  always_comb begin
    if (window_size == '0) begin
      win_w = CNT_W'(1);
    end else if (CNT_W'(window_size) > CNT_W'(WINDOW_MAX)) begin
      win_w = CNT_W'(WINDOW_MAX);
    end else begin
      win_w = CNT_W'(window_size);
    end
  end

  assign cand_raddr = cmd.rd_tail ? (head_r + count_r[ADDR_W-1:0] - ADDR_W'(1)) : head_r;

  assign deque_full = (count_r >= CNT_W'(WINDOW_MAX));
  assign head_adj   = deque_full ? (head_r + ADDR_W'(1)) : head_r;
  assign count_adj  = deque_full ? (count_r - CNT_W'(1)) : count_r;
  assign cand_waddr = head_adj + count_adj[ADDR_W-1:0];
  assign widx_inc   = CNT_W'(widx_r) + CNT_W'(1);

  assign head_base = in_first ? '0 : head_r;
  assign widx_base = in_first ? '0 : widx_r;
  assign seen_base = in_first ? '0 : seen_r;

  swm_ram #(.WIDTH(DATA_W), .DEPTH(WINDOW_MAX)) u_cand_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (cand_waddr),
    .wdata (sample_r),
    .raddr (cand_raddr),
    .rdata (cand_q)
  );

  swm_ram #(.WIDTH(DATA_W), .DEPTH(WINDOW_MAX)) u_rec_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (widx_r),
    .wdata (sample_r),
    .raddr (widx_r),
    .rdata (rec_q)
  );

  always_comb begin
    sample_nxt    = sample_r;
    last_nxt      = last_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    widx_nxt      = widx_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    if (cmd.accept) begin
      sample_nxt = in_sample;
      last_nxt   = in_last;
      head_nxt   = head_base;
      count_nxt  = in_first ? '0 : count_r;
      widx_nxt   = (CNT_W'(widx_base) >= win_w) ? '0 : widx_base;
      seen_nxt   = (seen_base > win_w) ? win_w : seen_base;
    end
    if (cmd.pop) begin
      head_nxt  = head_r + ADDR_W'(1);
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.drop_tail) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.push) begin
      head_nxt  = head_adj;
      count_nxt = count_adj + CNT_W'(1);
      widx_nxt  = (widx_inc >= win_w) ? '0 : widx_inc[ADDR_W-1:0];
      seen_nxt  = (seen_r < win_w) ? (seen_r + CNT_W'(1)) : seen_r;
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = cand_q;
      out_last_nxt  = last_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      widx_r      <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      widx_r      <= widx_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign stat.pop_hit      = (seen_r == win_w) && (count_r != '0) && (cand_q == rec_q);
  assign stat.count_zero   = (count_r == '0);
  assign stat.tail_smaller = ($signed(sample_r) > $signed(cand_q));
  assign stat.seen_full    = (seen_r == win_w);
  assign stat.out_free     = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_window_max = $signed(out_data_r);
  assign out_last       = out_last_r;

endmodule
`default_nettype wire

FILE: rtl/swm_ctrl.sv
// Controller: sequences head check, tail removal loop, push and result emission
`default_nettype none
module swm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire swm_pkg::swm_stat_t stat,
  output swm_pkg::swm_cmd_t       cmd
);
  import swm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RDH  = 8'b0000_0010,
    S_POP  = 8'b0000_0100,
    S_TAIL = 8'b0000_1000,
    S_CMP  = 8'b0001_0000,
    S_PUSH = 8'b0010_0000,
    S_RDO  = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_RDH;
        end
      end
      S_RDH: begin
        state_nxt = S_POP;
      end
      S_POP: begin
        cmd.pop   = stat.pop_hit;
        state_nxt = S_TAIL;
      end
      S_TAIL: begin
        if (stat.count_zero) begin
          state_nxt = S_PUSH;
        end else begin
          cmd.rd_tail = 1'b1;
          state_nxt   = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.tail_smaller) begin
          cmd.drop_tail = 1'b1;
          state_nxt     = S_TAIL;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = S_RDO;
      end
      S_RDO: begin
        state_nxt = stat.seen_full ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule
`default_nettype wire

FILE: rtl/sliding_window_maximum.sv
// Top level: sliding window maximum with APB window size register
//
// Usage:
//   in_req  : sample requests (sample, first_of_sequence, last_of_sequence),
//             accepted when valid and ready are both high.
//   out_res : results (window_max, last_result), one per sample once the
//             sequence has delivered window_size samples, none before.
//   cfg_*   : APB register window_size at address 0 (1..64, 0 acts as 1,
//             above 64 acts as 64). Write only while the block is idle.
// Timing:
//   Each sample steps from acceptance through head read, head check, a loop
//   over the deque tail, push, output read and, once the window is full,
//   emission, which waits for a stalled output register; ready is high
//   again only when the controller is back in idle. Each step of the tail
//   loop does one registered candidate RAM read; the loop removes smaller
//   candidates until the deque is empty or one at least as large stays.
//   A result is loaded at the edge where ready returns.
// Reset: synchronous, active low; deque empty, count zero, window size 1.
//   RAM contents are not cleared and no clearing pass is needed.
// Back-pressure: a result waits in the output register; the next sample is
//   accepted meanwhile and only its own emission waits for the register.
`default_nettype none
module sliding_window_maximum (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  swm_in_if.sink                             in_req,
  swm_out_if.source                          out_res,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [swm_pkg::PADDR_W-1:0]   cfg_paddr,
  input  wire logic [swm_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic      [swm_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                               cfg_pready
);
  import swm_pkg::*;

  logic [WS_W-1:0] window_size_r, window_size_nxt;
  logic            reg_sel;
  swm_cmd_t        cmd;
  swm_stat_t       stat;

  assign reg_sel    = (cfg_paddr[PADDR_W-1] == REG_WINDOW_SIZE);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_sel ? PDATA_W'(window_size_r) : '0;

  always_comb begin
    window_size_nxt = window_size_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && reg_sel) begin
      window_size_nxt = cfg_pwdata[WS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WS_W'(1);
    end else begin
      window_size_r <= window_size_nxt;
    end
  end

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swm_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .window_size    (window_size_r),
    .in_sample      (in_req.sample),
    .in_first       (in_req.first_of_sequence),
    .in_last        (in_req.last_of_sequence),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_res.valid),
    .out_ready      (out_res.ready),
    .out_window_max (out_res.window_max),
    .out_last       (out_res.last_result)
  );

endmodule
`default_nettype wire

FILE: rtl/swm_checker.sv
// Checker: port-level assertions for sliding_window_maximum, with bind
`default_nettype none
module swm_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [swm_pkg::DATA_W-1:0] out_window_max,
  input wire logic                              out_last
);

  // a taken request makes the block busy, so ready drops
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready high right after a request");

  // a result is loaded as the controller returns to idle
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result raised while busy");

  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready, 1) &&
                         !$past(in_valid && in_ready, 2) &&
                         !$past(in_valid && in_ready, 3))
    else $error("result too soon after request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_window_max) &&
                                  $stable(out_last))
    else $error("stalled result changed");

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .out_window_max (out_res.window_max),
  .out_last       (out_res.last_result)
);
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Testbench for sliding_window_maximum: directed and random sequences against a predictor
module testbench;
  import swm_pkg::*;

  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int DRAIN_CYCLES  = 200;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int CALM_ITEMS    = 250;

  localparam logic [PADDR_W-1:0] WINDOW_SIZE_ADDR = {REG_WINDOW_SIZE, 2'b00};
  localparam logic signed [DATA_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;

  typedef enum int {
    STYLE_WIDE, STYLE_NARROW, STYLE_EXTREME, STYLE_FALLING, STYLE_RISING
  } sample_style_t;

  typedef struct {
    logic signed [DATA_W-1:0] window_max;
    logic                     last_result;
  } window_result_t;

  logic clk;
  logic rst_n;

  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  swm_in_if  sample_ch ();
  swm_out_if max_ch ();

  sliding_window_maximum i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (sample_ch),
    .out_res     (max_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predictor state
  logic [WS_W-1:0]          win_size_reg;
  logic signed [DATA_W-1:0] candidates [WINDOW_MAX];
  logic [ADDR_W-1:0]        cand_head;
  logic [CNT_W-1:0]         cand_count;
  logic signed [DATA_W-1:0] delay_line [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]    line_written;
  logic [CNT_W-1:0]         wr_idx;
  logic [CNT_W-1:0]         seen;

  window_result_t pending_maxima [$];

  int  mismatches;
  int  samples_sent;
  int  cycle_count;
  bit  idle_on;
  bit  hold_off_req;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  function automatic logic [WS_W-1:0] effective_window();
    if (win_size_reg == '0) return 7'd1;
    if (win_size_reg > 7'(WINDOW_MAX)) return 7'(WINDOW_MAX);
    return win_size_reg;
  endfunction

  function automatic void predict_window_max(input logic signed [DATA_W-1:0] s,
                                             input logic first, input logic last);
    logic [WS_W-1:0]   w;
    logic [ADDR_W-1:0] tail;
    logic              done;
    window_result_t    res;
    w = effective_window();
    if (first) begin
      cand_head  = '0;
      cand_count = '0;
      wr_idx     = '0;
      seen       = '0;
    end
    if (wr_idx >= w) wr_idx = '0;
    if (seen > w) seen = w;
    if (seen == w && cand_count != '0 && candidates[cand_head] == delay_line[wr_idx[ADDR_W-1:0]])
    begin
      cand_head++;
      cand_count--;
    end
    done = 1'b0;
    while (!done && cand_count != '0) begin
      tail = cand_head + cand_count[ADDR_W-1:0] - 6'd1;
      if (s > candidates[tail]) cand_count--;
      else done = 1'b1;
    end
    if (cand_count >= CNT_W'(WINDOW_MAX)) begin
      cand_head++;
      cand_count--;
    end
    candidates[ADDR_W'(cand_head + cand_count[ADDR_W-1:0])] = s;
    cand_count++;
    delay_line[wr_idx[ADDR_W-1:0]]   = s;
    line_written[wr_idx[ADDR_W-1:0]] = 1'b1;
    wr_idx++;
    if (wr_idx >= w) wr_idx = '0;
    if (seen < w) seen++;
    if (seen == w) begin
      res.window_max  = candidates[cand_head];
      res.last_result = last;
      pending_maxima.insert(pending_maxima.size(), res);
    end
  endfunction

  always @(posedge clk) begin
    window_result_t exp_res;
    if (rst_n && max_ch.valid && max_ch.ready) begin
      if (pending_maxima.size() == 0) begin
        report_mismatch($sformatf("unexpected result window_max=%0d last=%0b",
                                  max_ch.window_max, max_ch.last_result));
      end else begin
        exp_res = pending_maxima[0];
        pending_maxima.delete(0);
        if (max_ch.window_max !== exp_res.window_max)
          report_mismatch($sformatf("window_max %0d, expected %0d",
                                    max_ch.window_max, exp_res.window_max));
        if (max_ch.last_result !== exp_res.last_result)
          report_mismatch($sformatf("last_result %0b, expected %0b",
                                    max_ch.last_result, exp_res.last_result));
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    max_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        max_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        max_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        max_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  task automatic send_sample(input logic signed [DATA_W-1:0] s, input logic first,
                             input logic last);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    sample_ch.valid             <= 1'b1;
    sample_ch.sample            <= s;
    sample_ch.first_of_sequence <= first;
    sample_ch.last_of_sequence  <= last;
    do @(posedge clk); while (!sample_ch.ready);
    predict_window_max(s, first, last);
    samples_sent++;
  endtask

  task automatic wait_block_idle();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (pending_maxima.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    data = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_window_reg(input logic [WS_W-1:0] exp_val);
    logic [PDATA_W-1:0] rd;
    cfg_read(WINDOW_SIZE_ADDR, rd);
    if (rd !== PDATA_W'(exp_val))
      report_mismatch($sformatf("window_size reads %0d, expected %0d", rd, exp_val));
  endtask

  // callers make sure the block is idle first
  task automatic write_window(input logic [PDATA_W-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= WINDOW_SIZE_ADDR;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    win_size_reg = value[WS_W-1:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    check_window_reg(value[WS_W-1:0]);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_sample(input sample_style_t style,
                                                           input logic signed [DATA_W-1:0] prev);
    case (style)
      STYLE_NARROW:  return int'($urandom_range(0, 8)) - 4;
      STYLE_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return SAMPLE_MIN;
          1:       return SAMPLE_MAX;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      STYLE_FALLING: return prev - int'($urandom_range(0, 3));
      STYLE_RISING:  return prev + int'($urandom_range(0, 5));
      default:       return $urandom;
    endcase
  endfunction

  task automatic send_run(input int len, input logic open, input sample_style_t style,
                          input bit noisy);
    logic signed [DATA_W-1:0] s;
    logic                     first;
    logic                     last;
    s = $urandom;
    for (int i = 0; i < len; i++) begin
      s     = pick_sample(style, s);
      first = (i == 0) && open;
      last  = (i == len - 1);
      if (noisy && $urandom_range(0, 15) == 0) first = 1'b1;
      if (noisy && $urandom_range(0, 15) == 0) last = ~last;
      send_sample(s, first, last);
    end
  endtask

  // window 1 out of reset, no first flag on the opening samples
  task automatic test_reset_state();
    check_window_reg(7'd1);
    send_sample(SAMPLE_MAX, 1'b0, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0, 1'b1);
    send_sample(-32'sd1, 1'b0, 1'b0);
    wait_block_idle();
  endtask

  task automatic test_directed();
    write_window(32'd3);
    send_sample(32'sd5, 1'b1, 1'b0);
    send_sample(32'sd5, 1'b0, 1'b0);
    send_sample(32'sd5, 1'b0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0, 1'b1);
    // sequence carries on past its last flag
    send_sample(32'sd0, 1'b0, 1'b0);
    send_sample(-32'sd1, 1'b0, 1'b1);
    // too short for the window
    send_sample(32'sd7, 1'b1, 1'b0);
    send_sample(32'sd8, 1'b0, 1'b1);
    wait_block_idle();
    write_window(32'd0);
    send_sample(-32'sd1, 1'b1, 1'b0);
    send_sample(-32'sd2, 1'b0, 1'b0);
    send_sample(32'sd3, 1'b0, 1'b1);
    wait_block_idle();
    write_window(32'd65);
    send_sample(SAMPLE_MAX, 1'b1, 1'b0);
    send_sample(32'sd1, 1'b0, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0, 1'b1);
    wait_block_idle();
  endtask

  // full-width window, falling samples keep every one as a candidate
  task automatic test_full_window();
    write_window(32'hFFFF_FFFF);
    send_run(WINDOW_MAX + 6, 1'b1, STYLE_FALLING, 1'b0);
    wait_block_idle();
  endtask

  task automatic test_back_pressure();
    write_window(32'd4);
    hold_off_req = 1'b1;
    send_run(40, 1'b1, STYLE_WIDE, 1'b0);
    wait_block_idle();
  endtask

  task automatic test_random_phases();
    int            start_count;
    int            runs;
    int            len;
    int            eff;
    logic [WS_W-1:0] w;
    logic [PDATA_W-1:0] value;
    logic          open;
    start_count = samples_sent;
    while (samples_sent - start_count < RANDOM_ITEMS) begin
      if (samples_sent - start_count > RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
      case ($urandom_range(0, 9))
        0:       w = 7'd0;
        1:       w = 7'd1;
        2:       w = 7'd64;
        3:       w = 7'd127;
        4:       w = 7'($urandom_range(65, 126));
        5, 6, 7: w = 7'($urandom_range(2, 8));
        default: w = 7'($urandom_range(1, 64));
      endcase
      value = PDATA_W'(w);
      if ($urandom_range(0, 3) == 0) value = ($urandom & ~32'h7F) | value;
      write_window(value);
      eff  = effective_window();
      runs = (eff > 16) ? $urandom_range(1, 2) : $urandom_range(1, 4);
      for (int r = 0; r < runs; r++) begin
        if (eff > 1 && $urandom_range(0, 5) == 0) len = $urandom_range(1, eff - 1);
        else len = eff + $urandom_range(0, 24);
        // a window change inside a sequence is only safe once the delay line is filled
        open = !(r == 0 && (&line_written) && $urandom_range(0, 3) == 0);
        send_run(len, open, sample_style_t'($urandom_range(0, 4)),
                 $urandom_range(0, 3) == 0);
      end
      wait_block_idle();
    end
  endtask

  initial begin
    rst_n                       = 1'b0;
    sample_ch.valid             = 1'b0;
    sample_ch.sample            = '0;
    sample_ch.first_of_sequence = 1'b0;
    sample_ch.last_of_sequence  = 1'b0;
    cfg_psel                    = 1'b0;
    cfg_penable                 = 1'b0;
    cfg_pwrite                  = 1'b0;
    cfg_paddr                   = '0;
    cfg_pwdata                  = '0;
    win_size_reg                = 7'd1;
    cand_head                   = '0;
    cand_count                  = '0;
    wr_idx                      = '0;
    seen                        = '0;
    line_written                = '0;
    mismatches                  = 0;
    samples_sent                = 0;
    cycle_count                 = 0;
    idle_on                     = 1'b1;
    hold_off_req                = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_directed();
    test_full_window();
    test_back_pressure();
    test_random_phases();
    wait_block_idle();

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
